/* src/byte_stuffer_with_xor_check_unit_assert.svh */
// Assertion macros used by the checker file of the byte stuffer.
// No dependencies; include by bare file name.
`ifndef BYTE_STUFFER_WITH_XOR_CHECK_UNIT_ASSERT_SVH
`define BYTE_STUFFER_WITH_XOR_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BSX_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("byte stuffer assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BSX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("byte stuffer assertion failed");

`endif

/* src/bsx_pkg.sv */
// Package of the byte stuffer: escape constants, sequence types and the
// escape function. No dependencies.
`timescale 1ns / 1ps

package bsx_pkg;

  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] FlagSub  = 8'h5E;
  localparam logic [7:0] EscSub   = 8'h5D;

  // A payload byte and its check byte give at most four output words.
  localparam int unsigned SeqDepth = 4;

  typedef logic [1:0] seq_idx_t;
  typedef logic [2:0] seq_cnt_t;

  typedef struct packed {
    logic       pair;
    logic [7:0] first;
    logic [7:0] second;
  } esc_t;

  function automatic esc_t escape_byte(input logic [7:0] v);
    esc_t e;
    e.pair   = 1'b0;
    e.first  = v;
    e.second = 8'h00;
    if (v == FlagByte) begin
      e.pair   = 1'b1;
      e.first  = EscByte;
      e.second = FlagSub;
    end else if (v == EscByte) begin
      e.pair   = 1'b1;
      e.first  = EscByte;
      e.second = EscSub;
    end
    return e;
  endfunction

endpackage

/* src/bsx_stream_if.sv */
// Valid/ready stream interfaces for the byte stuffer's input and output words.
// No dependencies.
`timescale 1ns / 1ps

interface bsx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bsx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* src/byte_stuffer_with_xor_check_unit.sv */
// Channel  | Dir | Payload                 | Handshake
// in_i     | in  | data_byte[7:0], last_byte | valid/ready, word taken when both high
// out_o    | out | out_byte[7:0], out_last   | valid/ready, word taken when both high
//
// An input word expands into one to four output words: one or two for the payload
// byte and, at the end of a frame, one or two for the check byte. One output word
// leaves per cycle while the output is not stalled; plain bytes stream at one a cycle
// when the output is ready. The first output word passes the sequence register and then
// the output register. rst_ni clears the check value and all valid state at once.
// A stalled output holds its word and the input waits until the queued expansion ends.
//
// Depends on bsx_pkg and the stream interfaces in bsx_stream_if.sv.
`timescale 1ns / 1ps

module byte_stuffer_with_xor_check_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  bsx_in_if.sink   in_i,
  bsx_out_if.source out_o
);
  import bsx_pkg::*;

  // Running XOR of the raw payload bytes of the current frame.
  logic [7:0] acc_q, acc_d;
  logic [7:0] check;

  // Expansion of the word being taken, built in one short combinational pass.
  esc_t       pay_esc, chk_esc;
  logic [7:0] slot_d [SeqDepth];
  seq_cnt_t   cnt_d;
  seq_idx_t   chk_pos;

  // Sequence register: the expansion of one input word, read out one word a cycle while the output register is free.
  logic [7:0] seq_q [SeqDepth];
  seq_cnt_t   seq_cnt_q;
  seq_idx_t   seq_idx_q;
  logic       seq_vld_q;
  logic       seq_eof_q;

  // Output register that separates the sequencer from the downstream stall.
  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic in_take, out_take, out_free, move, seq_at_end, seq_done;

  assign out_take   = out_vld_q & out_o.ready;
  assign out_free   = ~out_vld_q | out_o.ready;
  assign move       = seq_vld_q & out_free;
  assign seq_at_end = (seq_idx_q == seq_idx_t'(seq_cnt_q - 3'd1));
  assign seq_done   = move & seq_at_end;

  // A new word is taken when no expansion is queued or while the previous expansion hands over its final word.
  assign in_i.ready = ~seq_vld_q | seq_done;
  assign in_take    = in_i.valid & in_i.ready;

  assign out_o.valid    = out_vld_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

  // The check byte includes the current payload byte; the accumulator restarts
  // from zero after the last byte of a frame.
  always_comb begin
    check   = acc_q ^ in_i.data_byte;
    acc_d   = in_i.last_byte ? 8'h00 : check;
    pay_esc = escape_byte(in_i.data_byte);
    chk_esc = escape_byte(check);

    for (int i = 0; i < SeqDepth; i++) begin
      slot_d[i] = 8'h00;
    end
    slot_d[0] = pay_esc.first;
    slot_d[1] = pay_esc.second;
    cnt_d     = pay_esc.pair ? 3'd2 : 3'd1;
    chk_pos   = seq_idx_t'(cnt_d);

    // The check byte follows the payload word or its escape pair.
    if (in_i.last_byte) begin
      slot_d[chk_pos] = chk_esc.first;
      if (chk_esc.pair) begin
        slot_d[chk_pos + 2'd1] = chk_esc.second;
      end
      cnt_d = cnt_d + (chk_esc.pair ? 3'd2 : 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= 8'h00;
      seq_vld_q <= 1'b0;
      seq_cnt_q <= '0;
      seq_idx_q <= '0;
      seq_eof_q <= 1'b0;
    end else begin
      if (in_take) begin
        acc_q     <= acc_d;
        seq_vld_q <= 1'b1;
        seq_cnt_q <= cnt_d;
        seq_idx_q <= '0;
        seq_eof_q <= in_i.last_byte;
      end else if (seq_done) begin
        seq_vld_q <= 1'b0;
      end else if (move) begin
        seq_idx_q <= seq_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      for (int i = 0; i < SeqDepth; i++) begin
        seq_q[i] <= slot_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  // Only the final word of a frame's expansion carries the last mark.
  always_ff @(posedge clk_i) begin
    if (move) begin
      out_byte_q <= seq_q[seq_idx_q];
      out_last_q <= seq_eof_q & seq_at_end;
    end
  end

endmodule

/* src/bsx_checker.sv */
// Port-level checks of the byte stuffer, bound to its top level.
// Depends on bsx_pkg and byte_stuffer_with_xor_check_unit_assert.svh.
`timescale 1ns / 1ps
`include "byte_stuffer_with_xor_check_unit_assert.svh"

module bsx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);
  import bsx_pkg::*;

  logic out_stall, out_take, in_take, out_esc;

  assign out_stall = out_valid_i & ~out_ready_i;
  assign out_take  = out_valid_i & out_ready_i;
  assign in_take   = in_valid_i & in_ready_i;
  assign out_esc   = out_take & (out_byte_i == EscByte);

  // A stalled output word stays on the port unchanged.
  `BSX_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_byte_i) && $stable(out_last_i))

  // An escape word is always the first of a pair and never closes a frame.
  `BSX_ASSERT_NOW(a_esc_not_last, clk_i, rst_ni, out_esc, !out_last_i)

  // The second word of an escape pair follows right after the escape word.
  `BSX_ASSERT_NEXT(a_esc_pair, clk_i, rst_ni, out_esc, out_valid_i && (out_byte_i == FlagSub || out_byte_i == EscSub))

  // Every taken input word has output pending once it has passed the sequence register.
  `BSX_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_take, ##1 out_valid_i)

endmodule

bind byte_stuffer_with_xor_check_unit bsx_checker u_bsx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.out_last)
);
